// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the text console writer
// depends on nothing; used by tcw_addr, tcw_ctrl and text_console_writer
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_ERROR   = 8'd69;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_ATTR = 1'b0,
    REG_ERROR_ATTR   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_DATA,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_ZERO,
    ST_CLEAR,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [CELL_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// tcw_ram: generic single write port, single read port RAM with registered read
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcw_addr.sv =====
// tcw_addr: shared cell address unit, row * COLUMNS + col
// depends on tcw_pkg
module tcw_addr #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int AW      = 11
) (
  input  logic [tcw_pkg::ROW_W-1:0] row,
  input  logic [tcw_pkg::COL_W-1:0] col,
  output logic [AW-1:0]             addr
);

  localparam int PW = tcw_pkg::ROW_W + tcw_pkg::COL_W;

  logic [PW-1:0] lin;

  always_comb begin
    lin  = PW'(row) * PW'(COLUMNS) + PW'(col);
    addr = lin[AW-1:0];
  end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// tcw_ctrl: command sequencer, cursor, sweep counters and result register
// depends on tcw_pkg; drives the address unit and the cell RAM
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]    in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]   in_attribute,
  input  logic [tcw_pkg::COL_W-1:0]    in_col,
  input  logic [tcw_pkg::ROW_W-1:0]    in_row,
  input  logic                         in_use_cursor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::COL_W-1:0]    out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tcw_pkg::CHAR_W-1:0]   out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]   out_cell_attr,
  output logic                         out_range_error,
  input  logic [tcw_pkg::ATTR_W-1:0]   default_attr,
  input  logic [tcw_pkg::ATTR_W-1:0]   error_attr,
  output logic [tcw_pkg::ROW_W-1:0]    addr_row,
  output logic [tcw_pkg::COL_W-1:0]    addr_col,
  output tcw_pkg::mem_req_t            mem_req,
  input  logic [tcw_pkg::CELL_W-1:0]   rd_data
);

  localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(ROWS - 1);

  tcw_pkg::st_t                 state_r, state_nxt;
  tcw_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [tcw_pkg::CHAR_W-1:0]   char_r, char_nxt;
  logic [tcw_pkg::ATTR_W-1:0]   attr_r, attr_nxt;
  logic [tcw_pkg::COL_W-1:0]    tgt_col_r, tgt_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    tgt_row_r, tgt_row_nxt;
  logic                         err_r, err_nxt;
  logic [tcw_pkg::COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [tcw_pkg::COL_W-1:0]    sw_col_r, sw_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    sw_row_r, sw_row_nxt;
  logic [tcw_pkg::CELL_W-1:0]   res_cell_r, res_cell_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tcw_pkg::COL_W-1:0]    out_col_r, out_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [tcw_pkg::CELL_W-1:0]   out_cell_r, out_cell_nxt;
  logic                         out_err_r, out_err_nxt;

  logic                         done;
  logic                         out_free;
  logic                         outside;
  logic                         wrap;
  logic [tcw_pkg::CELL_W-1:0]   fin_cell;

  assign in_ready        = (state_r == tcw_pkg::ST_IDLE);
  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_cursor_col  = out_col_r;
  assign out_cursor_row  = out_row_r;
  assign out_cell_char   = out_cell_r[tcw_pkg::CHAR_W-1:0];
  assign out_cell_attr   = out_cell_r[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
  assign out_range_error = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      sw_col_r    <= '0;
      sw_row_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      sw_col_r    <= sw_col_nxt;
      sw_row_r    <= sw_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    char_r     <= char_nxt;
    attr_r     <= attr_nxt;
    tgt_col_r  <= tgt_col_nxt;
    tgt_row_r  <= tgt_row_nxt;
    err_r      <= err_nxt;
    res_cell_r <= res_cell_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_cell_r <= out_cell_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    char_nxt      = char_r;
    attr_nxt      = attr_r;
    tgt_col_nxt   = tgt_col_r;
    tgt_row_nxt   = tgt_row_r;
    err_nxt       = err_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    sw_col_nxt    = sw_col_r;
    sw_row_nxt    = sw_row_r;
    res_cell_nxt  = res_cell_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_cell_nxt  = out_cell_r;
    out_err_nxt   = out_err_r;
    mem_req       = '0;
    addr_row      = sw_row_r;
    addr_col      = sw_col_r;
    done          = 1'b0;
    fin_cell      = '0;
    outside       = !in_use_cursor && ((in_col > LAST_COL) || (in_row > LAST_ROW));
    wrap          = (char_r == tcw_pkg::CH_NEWLINE) || (tgt_col_r == LAST_COL);

    case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = tcw_pkg::cmd_t'(in_command);
          char_nxt    = in_char_code;
          attr_nxt    = (in_attribute == '0) ? default_attr : in_attribute;
          tgt_col_nxt = in_use_cursor ? cur_col_r : in_col;
          tgt_row_nxt = in_use_cursor ? cur_row_r : in_row;
          err_nxt     = outside && ((in_command == tcw_pkg::CMD_PUT) ||
                                    (in_command == tcw_pkg::CMD_READ));
          state_nxt   = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        addr_row = tgt_row_r;
        addr_col = tgt_col_r;
        case (cmd_r)
          tcw_pkg::CMD_PUT: begin
            if (err_r) begin
              // error marker goes to the last cell, cursor untouched
              addr_row      = LAST_ROW;
              addr_col      = LAST_COL;
              mem_req.we    = 1'b1;
              mem_req.wdata = {error_attr, tcw_pkg::CH_ERROR};
              done          = 1'b1;
            end else begin
              if (char_r != tcw_pkg::CH_NEWLINE) begin
                mem_req.we    = 1'b1;
                mem_req.wdata = {attr_r, char_r};
              end
              if (!wrap) begin
                cur_col_nxt = tgt_col_r + tcw_pkg::COL_W'(1);
                cur_row_nxt = tgt_row_r;
                done        = 1'b1;
              end else if (tgt_row_r != LAST_ROW) begin
                cur_col_nxt = '0;
                cur_row_nxt = tgt_row_r + tcw_pkg::ROW_W'(1);
                done        = 1'b1;
              end else begin
                // past the end of the screen: scroll, cursor to start of last row
                cur_col_nxt = '0;
                cur_row_nxt = LAST_ROW;
                sw_col_nxt  = '0;
                sw_row_nxt  = tcw_pkg::ROW_W'(1);
                state_nxt   = tcw_pkg::ST_SCROLL_RD;
              end
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            sw_col_nxt  = '0;
            sw_row_nxt  = '0;
            state_nxt   = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::CMD_READ: begin
            if (err_r) begin
              done = 1'b1;
            end else begin
              mem_req.re = 1'b1;
              state_nxt  = tcw_pkg::ST_READ_DATA;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      tcw_pkg::ST_READ_DATA: begin
        fin_cell = rd_data;
        done     = 1'b1;
      end
      tcw_pkg::ST_SCROLL_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = tcw_pkg::ST_SCROLL_WR;
      end
      tcw_pkg::ST_SCROLL_WR: begin
        // copy the cell just read one row up
        addr_row      = sw_row_r - tcw_pkg::ROW_W'(1);
        mem_req.we    = 1'b1;
        mem_req.wdata = rd_data;
        state_nxt     = tcw_pkg::ST_SCROLL_RD;
        if (sw_col_r == LAST_COL) begin
          sw_col_nxt = '0;
          if (sw_row_r == LAST_ROW) begin
            state_nxt = tcw_pkg::ST_ZERO;
          end else begin
            sw_row_nxt = sw_row_r + tcw_pkg::ROW_W'(1);
          end
        end else begin
          sw_col_nxt = sw_col_r + tcw_pkg::COL_W'(1);
        end
      end
      tcw_pkg::ST_ZERO: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = '0;
        if (sw_col_r == LAST_COL) begin
          done = 1'b1;
        end else begin
          sw_col_nxt = sw_col_r + tcw_pkg::COL_W'(1);
        end
      end
      tcw_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = {default_attr, tcw_pkg::CH_SPACE};
        if (sw_col_r == LAST_COL) begin
          sw_col_nxt = '0;
          if (sw_row_r == LAST_ROW) begin
            done = 1'b1;
          end else begin
            sw_row_nxt = sw_row_r + tcw_pkg::ROW_W'(1);
          end
        end else begin
          sw_col_nxt = sw_col_r + tcw_pkg::COL_W'(1);
        end
      end
      tcw_pkg::ST_FINISH: begin
        fin_cell = res_cell_r;
        done     = 1'b1;
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase

    // result leaves through the output register, or waits in res_cell_r (ST_FINISH) while that register is busy
    if (done) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_col_nxt   = cur_col_nxt;
        out_row_nxt   = cur_row_nxt;
        out_cell_nxt  = fin_cell;
        out_err_nxt   = err_r;
        state_nxt     = tcw_pkg::ST_IDLE;
      end else begin
        res_cell_nxt = fin_cell;
        state_nxt    = tcw_pkg::ST_FINISH;
      end
    end
  end

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r <= LAST_COL) && (cur_row_r <= LAST_ROW))
    else $error("cursor left the screen");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_IDLE) |-> !mem_req.we)
    else $error("cell write while idle");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_SCROLL_RD) |-> (cur_row_r == LAST_ROW) && (cur_col_r == '0))
    else $error("cursor not at start of last row during scroll");

  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sw_col_r <= LAST_COL) && (sw_row_r <= LAST_ROW))
    else $error("sweep counter out of range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_FINISH) && out_free |=> out_valid_r && (state_r == tcw_pkg::ST_IDLE))
    else $error("waiting result not delivered");

endmodule

// ===== rtl/text_console_writer.sv =====
// text_console_writer: text-mode console, top level
// depends on tcw_pkg, tcw_ram, tcw_addr, tcw_ctrl
//
// Usage: one command per input transfer (in_valid/in_ready), one result per
// command on the output channel (out_valid/out_ready). Put writes a character
// at a given position or at the cursor (newline moves to the next row), clear
// fills the screen with spaces, read returns one cell. The result carries the
// cursor after the command, the cell read and the range error flag.
// Sequencing: a plain put passes through the idle and execute states, a read
// adds the read-data state, a clear writes every cell in turn, and a put that
// scrolls copies rows 1 to ROWS-1 up one row and then zeroes the last row; the
// result is in the output register at the same edge that in_ready returns.
// The single cell address unit, shared by the read and write ports of the RAM,
// sets this order; scrolling reads and writes each cell in turn.
// The block takes the next command while a result still waits; a stalled
// receiver only holds the block at the end of that next command.
// Reset: cursor to 0, default_attr 15, error_attr 244; the cell store is not
// cleared, cells are undefined until written or cleared.
// Configuration writes (cfg_we) belong in times when the block is idle and no
// result is pending.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]      in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]     in_attribute,
  input  logic [tcw_pkg::COL_W-1:0]      in_col,
  input  logic [tcw_pkg::ROW_W-1:0]      in_row,
  input  logic                           in_use_cursor,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcw_pkg::COL_W-1:0]      out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]      out_cursor_row,
  output logic [tcw_pkg::CHAR_W-1:0]     out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]     out_cell_attr,
  output logic                           out_range_error,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [tcw_pkg::ATTR_W-1:0]  default_attr_r;
  logic [tcw_pkg::ATTR_W-1:0]  error_attr_r;
  logic [tcw_pkg::ROW_W-1:0]   addr_row;
  logic [tcw_pkg::COL_W-1:0]   addr_col;
  logic [AW-1:0]               cell_addr;
  tcw_pkg::mem_req_t           mem_req;
  logic [tcw_pkg::CELL_W-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= tcw_pkg::DEFAULT_ATTR_RST;
      error_attr_r   <= tcw_pkg::ERROR_ATTR_RST;
    end else if (cfg_we) begin
      case (tcw_pkg::cfg_reg_t'(cfg_index))
        tcw_pkg::REG_DEFAULT_ATTR: default_attr_r <= cfg_wdata;
        tcw_pkg::REG_ERROR_ATTR:   error_attr_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_char_code    (in_char_code),
    .in_attribute    (in_attribute),
    .in_col          (in_col),
    .in_row          (in_row),
    .in_use_cursor   (in_use_cursor),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cursor_col  (out_cursor_col),
    .out_cursor_row  (out_cursor_row),
    .out_cell_char   (out_cell_char),
    .out_cell_attr   (out_cell_attr),
    .out_range_error (out_range_error),
    .default_attr    (default_attr_r),
    .error_attr      (error_attr_r),
    .addr_row        (addr_row),
    .addr_col        (addr_col),
    .mem_req         (mem_req),
    .rd_data         (rd_data)
  );

  tcw_addr #(
    .COLUMNS (COLUMNS),
    .AW      (AW)
  ) u_addr (
    .row  (addr_row),
    .col  (addr_col),
    .addr (cell_addr)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (cell_addr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (cell_addr),
    .rdata (rd_data)
  );

endmodule
